>>> rtl/core/fpa_pkg.sv
// package: fixed-point alu constants, mode codes, pipeline stage type and divide step
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int DVD_W     = DATA_W + FRAC_BITS;

   typedef enum logic [3:0] {
      MODE_ADD  = 4'd0,
      MODE_SUB  = 4'd1,
      MODE_MUL  = 4'd2,
      MODE_DIV  = 4'd3,
      MODE_MIN  = 4'd4,
      MODE_MAX  = 4'd5,
      MODE_INC  = 4'd6,
      MODE_DEC  = 4'd7,
      MODE_I2F  = 4'd8,
      MODE_F2I  = 4'd9
   } mode_type;

   typedef struct packed {
      logic [3:0]        mode;
      logic [DATA_W-1:0] res;
      logic              less;
      logic              equal;
      logic              greater;
      logic              dz;
      logic              neg;
      logic [DATA_W-1:0] rem;
      logic [DVD_W-1:0]  dvd;
      logic [DATA_W-1:0] dvs;
   } stage_type;

   // one restoring division step, quotient bits shift into the dividend's low end
   function automatic stage_type div_step(input stage_type s);
      stage_type       r;
      logic [DATA_W:0] trial;
      logic [DATA_W:0] diff;
      r     = s;
      trial = {s.rem, s.dvd[DVD_W-1]};
      diff  = trial - {1'b0, s.dvs};
      if (!diff[DATA_W]) begin
         r.rem = diff[DATA_W-1:0];
         r.dvd = {s.dvd[DVD_W-2:0], 1'b1};
      end else begin
         r.rem = trial[DATA_W-1:0];
         r.dvd = {s.dvd[DVD_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> rtl/core/fpa_if.sv
// interfaces: request and response channels of the fixed-point alu
interface fpa_req_if;
   import fpa_pkg::*;
   logic              valid;
   logic              ready;
   logic [3:0]        mode;
   logic signed [DATA_W-1:0] operand_a;
   logic signed [DATA_W-1:0] operand_b;
   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
   import fpa_pkg::*;
   logic              valid;
   logic              ready;
   logic signed [DATA_W-1:0] result_value;
   logic              a_less;
   logic              a_equal;
   logic              a_greater;
   logic              div_by_zero;
   modport source (output valid, result_value, a_less, a_equal, a_greater, div_by_zero,
                   input ready);
   modport sink   (input valid, result_value, a_less, a_equal, a_greater, div_by_zero,
                   output ready);
endinterface

>>> rtl/core/fixed_point_alu_q24_8_unit.sv
// top level: pipelined signed fixed-point alu with restoring divider
//
//  channel    dir  handshake    payload
//  req_chan   in   valid/ready  mode, operand_a, operand_b
//  rsp_chan   out  valid/ready  result_value, a_less, a_equal, a_greater, div_by_zero
//
// one transaction per cycle unless the output stalls; stages are the entry stage, one
// divider stage per dividend bit and the output register; DVD_W = 32 + FRAC_BITS
// the divider's bit-per-stage chain sets the depth; the multiply sits in the entry stage
// synchronous reset clears all valid bits
// a stalled output freezes the pipeline; req_chan.ready = rsp_chan.ready | !out_valid_ff
module fixed_point_alu_q24_8_unit
   import fpa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   fpa_req_if.sink     req_chan,
   fpa_rsp_if.source   rsp_chan
);

   stage_type              st_ff    [0:DVD_W];
   stage_type              st_in    [1:DVD_W];
   stage_type              entry_in;
   logic      [DVD_W:0]    valid_ff;
   logic                   adv;

   logic                   out_valid_ff;
   logic      [DATA_W-1:0] out_value_ff, out_value_in;
   logic                   out_less_ff, out_equal_ff, out_greater_ff, out_dz_ff;

   logic signed [DATA_W-1:0]   a, b;
   logic signed [2*DATA_W-1:0] prod;
   logic        [DATA_W-1:0]   abs_a, abs_b;
   logic        [DATA_W-1:0]   quot;

   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   assign a    = req_chan.operand_a;
   assign b    = req_chan.operand_b;
   assign prod = a * b;
   assign abs_a = a[DATA_W-1] ? (-a) : a;
   assign abs_b = b[DATA_W-1] ? (-b) : b;

   // entry stage
   always_comb begin
      entry_in         = '0;
      entry_in.mode    = req_chan.mode;
      entry_in.less    = a < b;
      entry_in.equal   = a == b;
      entry_in.greater = a > b;
      entry_in.dz      = (req_chan.mode == MODE_DIV) && (b == '0);
      entry_in.neg     = a[DATA_W-1] ^ b[DATA_W-1];
      entry_in.dvd     = {abs_a, {FRAC_BITS{1'b0}}};
      entry_in.dvs     = abs_b;
      unique case (req_chan.mode)
         MODE_ADD: entry_in.res = a + b;
         MODE_SUB: entry_in.res = a - b;
         MODE_MUL: entry_in.res = prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
         MODE_MIN: entry_in.res = (a < b) ? a : b;
         MODE_MAX: entry_in.res = (a > b) ? a : b;
         MODE_INC: entry_in.res = a + 1'b1;
         MODE_DEC: entry_in.res = a - 1'b1;
         MODE_I2F: entry_in.res = a << FRAC_BITS;
         MODE_F2I: entry_in.res = a >>> FRAC_BITS;
         default:  entry_in.res = '0;
      endcase
   end

   for (genvar k = 1; k <= DVD_W; k++) begin : g_div
      assign st_in[k] = div_step(st_ff[k-1]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= entry_in;
         for (int k = 1; k <= DVD_W; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DVD_W-1:0], req_chan.valid};
      end
   end

   // final select and quotient sign fix
   always_comb begin
      quot = st_ff[DVD_W].dvd[DATA_W-1:0];
      if (st_ff[DVD_W].neg) begin
         quot = -quot;
      end
      if (st_ff[DVD_W].mode == MODE_DIV) begin
         out_value_in = st_ff[DVD_W].dz ? '0 : quot;
      end else begin
         out_value_in = st_ff[DVD_W].res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= valid_ff[DVD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_value_ff   <= out_value_in;
         out_less_ff    <= st_ff[DVD_W].less;
         out_equal_ff   <= st_ff[DVD_W].equal;
         out_greater_ff <= st_ff[DVD_W].greater;
         out_dz_ff      <= st_ff[DVD_W].dz;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_value = out_value_ff;
   assign rsp_chan.a_less       = out_less_ff;
   assign rsp_chan.a_equal      = out_equal_ff;
   assign rsp_chan.a_greater    = out_greater_ff;
   assign rsp_chan.div_by_zero  = out_dz_ff;

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot({out_less_ff, out_equal_ff, out_greater_ff}))
      else $error("compare flags not one-hot");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dz_ff) |-> (out_value_ff == '0))
      else $error("zero divisor result not zero");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && (valid_ff == '0)))
      else $error("pipeline not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(valid_ff) && $stable(out_value_ff)))
      else $error("pipeline moved during stall");

endmodule
